/* design/swmf_pkg.sv */
// Shared types and constants for the sliding window median filter.
`default_nettype none

package swmf_pkg;

  // Width of the window length register
  localparam int CFG_W = 5;

  // Control handed from one cell to its right neighbor
  typedef struct packed {
    logic kill;  // an evicted entry sits at or left of this cell
    logic gt;    // this cell's compacted entry is empty or above the new sample
  } link_t;

endpackage

`default_nettype wire

/* design/sliding_window_median_filter.sv */
// Top level of the sliding window median filter: cell chain, window control, output stage.
//
//  channel    dir  handshake                    payload
//  s_axis     in   s_axis_tvalid/s_axis_tready  tdata: sample
//  m_axis     out  m_axis_tvalid/m_axis_tready  tdata: median
//  cfg        in   cfg_we                       cfg_wdata: window_length
//
// One sample per cycle while the output accepts: the chain inserts the new sample and evicts
// the oldest, and the median is picked from the updated chain into the output register.
// The rate is set by the single pending slot between the chain and the output register.
// Reset or a length write empties the window at once; no clearing pass.
// A stalled output holds its beat and blocks input once one more result is pending.
`default_nettype none

module sliding_window_median_filter #(
  parameter int MAX_WINDOW   = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [swmf_pkg::CFG_W-1:0]            cfg_wdata,     // window_length
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          m_axis_tdata   // [SAMPLE_WIDTH-1:0] median
);

  localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int LW  = $clog2(MAX_WINDOW + 1);
  localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [LW-1:0]           len;
  logic [LW-1:0]           len_next;
  logic [LW-1:0]           cnt;
  logic                    full;
  logic [AW-1:0]           evict_age;
  logic                    pend;
  logic                    load;
  logic                    accept;
  logic [SAMPLE_WIDTH-1:0] med;
  logic [SAMPLE_WIDTH-1:0] med_sel;
  logic [SAMPLE_WIDTH-1:0] sample;

  logic [MAX_WINDOW-1:0]   c_valid;
  logic [AW-1:0]           c_age    [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] c_value  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]   c_rvalid;
  logic [AW-1:0]           c_rage   [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] c_rvalue [MAX_WINDOW];
  swmf_pkg::link_t         c_link   [MAX_WINDOW];

  assign sample    = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign full      = (cnt == len);
  assign evict_age = AW'(len - LW'(1));

  // Handshake: one result may wait in the chain while the output register holds another
  assign load          = pend && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !pend || load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Clamp the written length into 1..MAX_WINDOW
  always_comb begin
    if (cfg_wdata == '0) begin
      len_next = LW'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_WINDOW)) begin
      len_next = LW'(MAX_WINDOW);
    end else begin
      len_next = LW'(cfg_wdata);
    end
  end

  // Hold window length and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= (MAX_WINDOW < 16) ? LW'(MAX_WINDOW) : LW'(16);
      cnt <= '0;
    end else if (cfg_we) begin
      len <= len_next;
      cnt <= '0;
    end else if (accept && !full) begin
      cnt <= cnt + LW'(1);
    end
  end

  // Chain of sorted cells, smallest at cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                    rn_valid;
    logic [AW-1:0]           rn_age;
    logic [SAMPLE_WIDTH-1:0] rn_value;
    logic                    ln_rvalid;
    logic [AW-1:0]           ln_rage;
    logic [SAMPLE_WIDTH-1:0] ln_rvalue;
    swmf_pkg::link_t         ln_link;

    if (i == MAX_WINDOW - 1) begin : g_last
      assign rn_valid = 1'b0;
      assign rn_age   = '0;
      assign rn_value = '0;
    end else begin : g_mid
      assign rn_valid = c_valid[i+1];
      assign rn_age   = c_age[i+1];
      assign rn_value = c_value[i+1];
    end

    if (i == 0) begin : g_first
      assign ln_rvalid = 1'b0;
      assign ln_rage   = '0;
      assign ln_rvalue = '0;
      assign ln_link   = '0;
    end else begin : g_rest
      assign ln_rvalid = c_rvalid[i-1];
      assign ln_rage   = c_rage[i-1];
      assign ln_rvalue = c_rvalue[i-1];
      assign ln_link   = c_link[i-1];
    end

    swmf_cell #(
      .DW (SAMPLE_WIDTH),
      .AW (AW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (cfg_we),
      .shift_en  (accept),
      .full      (full),
      .evict_age (evict_age),
      .sample    (sample),
      .rn_valid  (rn_valid),
      .rn_age    (rn_age),
      .rn_value  (rn_value),
      .ln_rvalid (ln_rvalid),
      .ln_rage   (ln_rage),
      .ln_rvalue (ln_rvalue),
      .ln_link   (ln_link),
      .valid     (c_valid[i]),
      .age       (c_age[i]),
      .value     (c_value[i]),
      .rvalid    (c_rvalid[i]),
      .rage      (c_rage[i]),
      .rvalue    (c_rvalue[i]),
      .link      (c_link[i])
    );
  end

  // Pick the middle cell of the held samples
  always_comb begin
    med_sel = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if ((cnt >> 1) == LW'(i)) begin
        med_sel = c_value[i];
      end
    end
  end

  // Track the result waiting in the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (load) begin
      pend <= 1'b0;
    end
  end

  // Output register: load the median, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      med <= med_sel;
    end
  end

  assign m_axis_tdata = TDW'(med);

  // Fill count never passes the window length
  a_cnt_le_len: assert property (@(posedge clk) disable iff (rst) cnt <= len)
    else $error("fill count above window length");

  // Occupied cells match the fill count
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(c_valid) == 32'(cnt))
    else $error("cell valid bits disagree with fill count");

  // An accepted sample leaves a pending result
  a_accept_pend: assert property (@(posedge clk) disable iff (rst) accept |=> pend)
    else $error("accepted sample left no pending result");

endmodule

`default_nettype wire

/* design/swmf_cell.sv */
// One cell of the sorted chain: holds one sample with its age and valid flag.
`default_nettype none

module swmf_cell #(
  parameter int DW = 16,
  parameter int AW = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 clear,
  input  wire logic                 shift_en,
  input  wire logic                 full,
  input  wire logic [AW-1:0]        evict_age,
  input  wire logic [DW-1:0]        sample,
  // right neighbor's stored entry
  input  wire logic                 rn_valid,
  input  wire logic [AW-1:0]        rn_age,
  input  wire logic [DW-1:0]        rn_value,
  // left neighbor's compacted entry and link
  input  wire logic                 ln_rvalid,
  input  wire logic [AW-1:0]        ln_rage,
  input  wire logic [DW-1:0]        ln_rvalue,
  input  wire swmf_pkg::link_t      ln_link,
  // own stored entry
  output logic                      valid,
  output logic [AW-1:0]             age,
  output logic [DW-1:0]             value,
  // own compacted entry and link
  output logic                      rvalid,
  output logic [AW-1:0]             rage,
  output logic [DW-1:0]             rvalue,
  output swmf_pkg::link_t           link
);

  logic          ev;
  logic          valid_next;
  logic [AW-1:0] age_next;
  logic [DW-1:0] value_next;

  // Close the gap left by the evicted entry, then find the insert point
  always_comb begin
    ev        = full && valid && (age == evict_age);
    link.kill = ln_link.kill || ev;
    if (link.kill) begin
      rvalid = rn_valid;
      rage   = rn_age;
      rvalue = rn_value;
    end else begin
      rvalid = valid;
      rage   = age;
      rvalue = value;
    end
    link.gt = !rvalid || ($signed(rvalue) > $signed(sample));
  end

  // Take the left entry, the new sample, or keep the compacted entry
  always_comb begin
    if (link.gt && ln_link.gt) begin
      valid_next = ln_rvalid;
      age_next   = ln_rage + AW'(1);
      value_next = ln_rvalue;
    end else if (link.gt) begin
      valid_next = 1'b1;
      age_next   = '0;
      value_next = sample;
    end else begin
      valid_next = rvalid;
      age_next   = rage + AW'(1);
      value_next = rvalue;
    end
  end

  // Hold the valid flag under reset and restart
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      valid <= valid_next;
    end
  end

  // Advance the payload on each inserted sample
  always_ff @(posedge clk) begin
    if (shift_en) begin
      age   <= age_next;
      value <= value_next;
    end
  end

endmodule

`default_nettype wire
